// ----- hdl/pflim_pkg.sv -----
// Shared types, constants and saturation helpers of the proxy force limiter.
`timescale 1ns / 1ps
package pflim_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [25:0] STIFFNESS_RST = 26'd16384000;
    localparam logic [30:0] MAX_STEP_RST  = 31'd6554;
    localparam logic [30:0] MAX_NORM_RST  = 31'd655360;

    localparam logic [1:0] REG_STIFFNESS = 2'd0;
    localparam logic [1:0] REG_MAX_STEP  = 2'd1;
    localparam logic [1:0] REG_MAX_NORM  = 2'd2;

    localparam logic OP_LOAD_ROW = 1'b0;
    localparam logic OP_CONTROL  = 1'b1;

    // Request to the shared root and divide unit.
    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } t_du_req;

    // Status back from the shared root and divide unit.
    typedef struct packed {
        logic        done;
        logic [31:0] res;
    } t_du_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [38:0] v);
        logic signed [23:0] r;
        if (v > 39'sd8388607) begin
            r = 24'sh7fffff;
        end else if (v < -39'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/pflim_divsqrt.sv -----
// Shared one-bit-per-cycle unit for integer square root and unsigned division.
`timescale 1ns / 1ps
module pflim_divsqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pflim_pkg::t_du_req i_req,
    input  logic [63:0]       i_a,
    input  logic [31:0]       i_d,
    output pflim_pkg::t_du_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic        r_mode;
    logic [4:0]  r_cnt;
    logic [63:0] r_src;
    logic [33:0] r_rem;
    logic [31:0] r_res;
    logic [31:0] r_d;

    logic [35:0] w_rem_sh;
    logic [35:0] w_trial;
    logic [35:0] w_sub;
    logic        w_ge;

    // Square root takes two radicand bits a step, division one dividend bit.
    always_comb begin
        if (r_mode) begin
            w_rem_sh = {r_rem, r_src[63:62]};
            w_trial  = {2'b00, r_res, 2'b01};
        end else begin
            w_rem_sh = {1'b0, r_rem, r_src[63]};
            w_trial  = {4'b0000, r_d};
        end
        w_ge  = (w_rem_sh >= w_trial);
        w_sub = w_rem_sh - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_mode <= i_req.sqrt_mode;
                r_d    <= i_d;
                r_res  <= 32'd0;
                if (i_req.sqrt_mode) begin
                    r_src <= i_a;
                    r_rem <= 34'd0;
                end else begin
                    // The quotient fits 32 bits, so the upper half is already a remainder.
                    r_src <= {i_a[31:0], 32'd0};
                    r_rem <= {2'b00, i_a[63:32]};
                end
            end else if (r_busy) begin
                r_src <= r_mode ? {r_src[61:0], 2'b00} : {r_src[62:0], 1'b0};
                r_rem <= w_ge ? w_sub[33:0] : w_rem_sh[33:0];
                r_res <= {r_res[30:0], w_ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

// ----- hdl/proxy_force_rate_and_magnitude_limiter.sv -----
// Top level of the proxy force slew-rate and norm limiter.
`timescale 1ns / 1ps
// The block holds a 3x3 force projection matrix, loaded one row per request with op 0,
// and the force it commanded last. A control request (op 1) forms the error between proxy
// and robot position, projects it, scales it by the stiffness, limits the change against
// the previous force in Euclidean norm, clamps the norm, and returns the force together
// with the saturated motion target. One shared 33x33 multiplier and one shared unit for
// square root and division, which retires one result bit per cycle, do all arithmetic under
// a small sequencer; the block takes no new request while a control request is in work.
// Each limit that acts adds one square root and three divisions in the shared unit, so a
// request that hits both limits runs two square roots and six divisions. The finished
// result waits in an output register, so the next request can enter while it is unread.
// Configuration writes are always taken; they belong between control requests, while no
// control request is in work, and then apply to the next one.
module proxy_force_rate_and_magnitude_limiter #(
    parameter int FRAC_BITS = pflim_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [1:0]         i_row_index,
    input  logic signed [23:0] i_first_x,
    input  logic signed [23:0] i_first_y,
    input  logic signed [23:0] i_first_z,
    input  logic signed [23:0] i_robot_x,
    input  logic signed [23:0] i_robot_y,
    input  logic signed [23:0] i_robot_z,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_force_x,
    output logic signed [31:0] o_force_y,
    output logic signed [31:0] o_force_z,
    output logic signed [23:0] o_motion_target_x,
    output logic signed [23:0] o_motion_target_y,
    output logic signed [23:0] o_motion_target_z,
    output logic               o_slew_limited,
    output logic               o_norm_clamped,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PMUL, ST_PACC, ST_KLO, ST_KHI, ST_KACC,
        ST_SMUL, ST_SACC, ST_MMUL, ST_CMP, ST_SQRT,
        ST_QMUL, ST_QDIV, ST_QWAIT, ST_OUT
    } t_state;

    localparam logic signed [49:0] PE_HI = 50'sh10_0000_0000;
    localparam logic signed [49:0] PE_LO = -PE_HI;

    t_state r_state;

    logic [25:0] r_k;
    logic [30:0] r_mfs;
    logic [30:0] r_mfn;

    logic signed [23:0] r_p [9];
    logic signed [31:0] r_prev [3];

    logic signed [23:0] r_first [3];
    logic signed [24:0] r_err [3];
    logic signed [37:0] r_pe [3];
    logic signed [31:0] r_force [3];
    logic signed [31:0] r_diff [3];

    logic [1:0]         r_i;
    logic [1:0]         r_j;
    logic               r_ph;
    logic signed [49:0] r_acc;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_lo;
    logic [63:0]        r_s;
    logic [31:0]        r_n;
    logic               r_neg;
    logic               r_slew;
    logic               r_clamp;

    logic signed [32:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [65:0] w_mul;
    logic [3:0]         w_pidx;
    logic signed [31:0] w_vec;
    logic [30:0]        w_lim;
    logic signed [49:0] w_acc;
    logic signed [49:0] w_acc_sh;
    logic signed [37:0] w_pe;
    logic signed [63:0] w_kpe;
    logic signed [31:0] w_fk;
    logic signed [31:0] w_dk;
    logic [63:0]        w_s;
    logic               w_over;
    logic signed [32:0] w_q;
    logic signed [23:0] w_mt [3];
    logic               w_out_free;
    pflim_pkg::t_du_req w_du_req;
    pflim_pkg::t_du_rsp w_du_rsp;
    logic [63:0]        w_du_a;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_out_free  = !o_out_valid || !i_out_stall;

    assign w_pidx = 4'(r_i) * 4'd3 + 4'(r_j);
    // Phase 0 works on the change of force, phase 1 on the force itself.
    assign w_vec  = r_ph ? r_force[r_i] : r_diff[r_i];
    assign w_lim  = r_ph ? r_mfn : r_mfs;

    // Operand selection of the shared multiplier.
    always_comb begin
        case (r_state)
            ST_PMUL: begin
                w_ma = 33'(r_p[w_pidx]);
                w_mb = 33'(r_err[r_j]);
            end
            ST_KLO: begin
                w_ma = 33'(r_k);
                w_mb = {14'd0, r_pe[r_i][18:0]};
            end
            ST_KHI: begin
                w_ma = 33'(r_k);
                w_mb = 33'($signed(r_pe[r_i][37:19]));
            end
            ST_SMUL: begin
                w_ma = 33'(w_vec);
                w_mb = 33'(w_vec);
            end
            ST_MMUL: begin
                w_ma = 33'(w_lim);
                w_mb = 33'(w_lim);
            end
            ST_QMUL: begin
                w_ma = 33'(w_vec);
                w_mb = 33'(w_lim);
            end
            default: begin
                w_ma = 33'sd0;
                w_mb = 33'sd0;
            end
        endcase
        w_mul = w_ma * w_mb;
    end

    always_comb begin
        w_acc    = ((r_j == 2'd0) ? 50'sd0 : r_acc) + r_prod[49:0];
        w_acc_sh = w_acc >>> FRAC_BITS;
        if (w_acc_sh > PE_HI) begin
            w_pe = PE_HI[37:0];
        end else if (w_acc_sh < PE_LO) begin
            w_pe = PE_LO[37:0];
        end else begin
            w_pe = w_acc_sh[37:0];
        end
        // The stiffness product is assembled from two partial products.
        w_kpe  = (r_prod <<< 19) + r_lo;
        w_fk   = pflim_pkg::sat32(w_kpe >>> FRAC_BITS);
        w_dk   = pflim_pkg::sat32(64'(w_fk) - 64'(r_prev[r_i]));
        w_s    = ((r_i == 2'd0) ? 64'd0 : r_s) + r_prod;
        w_over = (r_s > r_prod);
        w_q    = r_neg ? -$signed({1'b0, w_du_rsp.res}) : $signed({1'b0, w_du_rsp.res});
        for (int m = 0; m < 3; m++) begin
            w_mt[m] = pflim_pkg::sat24(39'(r_first[m]) - 39'(r_pe[m]));
        end
    end

    always_comb begin
        w_du_req.start     = 1'b0;
        w_du_req.sqrt_mode = 1'b0;
        w_du_a             = 64'(r_prod);
        if (r_state == ST_CMP && w_over) begin
            w_du_req.start     = 1'b1;
            w_du_req.sqrt_mode = 1'b1;
            w_du_a             = r_s;
        end else if (r_state == ST_QDIV) begin
            w_du_req.start = 1'b1;
            w_du_a         = r_prod[63] ? 64'(-r_prod) : 64'(r_prod);
        end
    end

    pflim_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_du_req),
        .i_a     (w_du_a),
        .i_d     (r_n),
        .o_rsp   (w_du_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            o_out_valid <= 1'b0;
            r_k         <= pflim_pkg::STIFFNESS_RST;
            r_mfs       <= pflim_pkg::MAX_STEP_RST;
            r_mfn       <= pflim_pkg::MAX_NORM_RST;
            for (int m = 0; m < 9; m++) begin
                r_p[m] <= 24'sd0;
            end
            for (int m = 0; m < 3; m++) begin
                r_prev[m] <= 32'sd0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    pflim_pkg::REG_STIFFNESS: r_k   <= i_cfg_data[25:0];
                    pflim_pkg::REG_MAX_STEP:  r_mfs <= i_cfg_data;
                    pflim_pkg::REG_MAX_NORM:  r_mfn <= i_cfg_data;
                    default: ;
                endcase
            end

            // A result read in the cycle that a new one is loaded is replaced below.
            if (o_out_valid && !i_out_stall && r_state != ST_OUT) begin
                o_out_valid <= 1'b0;
            end

            r_prod <= w_mul[63:0];

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        if (i_op == pflim_pkg::OP_LOAD_ROW) begin
                            // A row index of three loads nothing.
                            if (i_row_index != 2'd3) begin
                                r_p[4'(i_row_index) * 4'd3]        <= i_first_x;
                                r_p[4'(i_row_index) * 4'd3 + 4'd1] <= i_first_y;
                                r_p[4'(i_row_index) * 4'd3 + 4'd2] <= i_first_z;
                            end
                        end else begin
                            r_first[0] <= i_first_x;
                            r_first[1] <= i_first_y;
                            r_first[2] <= i_first_z;
                            r_err[0]   <= 25'(i_first_x) - 25'(i_robot_x);
                            r_err[1]   <= 25'(i_first_y) - 25'(i_robot_y);
                            r_err[2]   <= 25'(i_first_z) - 25'(i_robot_z);
                            r_i        <= 2'd0;
                            r_j        <= 2'd0;
                            r_ph       <= 1'b0;
                            r_slew     <= 1'b0;
                            r_clamp    <= 1'b0;
                            r_state    <= ST_PMUL;
                        end
                    end
                end
                ST_PMUL: r_state <= ST_PACC;
                ST_PACC: begin
                    r_acc <= w_acc;
                    if (r_j == 2'd2) begin
                        r_pe[r_i] <= w_pe;
                        r_j       <= 2'd0;
                        r_state   <= ST_KLO;
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= ST_PMUL;
                    end
                end
                ST_KLO: r_state <= ST_KHI;
                ST_KHI: begin
                    r_lo    <= r_prod;
                    r_state <= ST_KACC;
                end
                ST_KACC: begin
                    r_force[r_i] <= w_fk;
                    r_diff[r_i]  <= w_dk;
                    if (r_i == 2'd2) begin
                        r_i     <= 2'd0;
                        r_state <= ST_SMUL;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= ST_PMUL;
                    end
                end
                ST_SMUL: r_state <= ST_SACC;
                ST_SACC: begin
                    r_s <= w_s;
                    if (r_i == 2'd2) begin
                        r_i     <= 2'd0;
                        r_state <= ST_MMUL;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= ST_SMUL;
                    end
                end
                ST_MMUL: r_state <= ST_CMP;
                ST_CMP: begin
                    if (w_over) begin
                        if (r_ph) begin
                            r_clamp <= 1'b1;
                        end else begin
                            r_slew <= 1'b1;
                        end
                        r_state <= ST_SQRT;
                    end else if (r_ph) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_ph    <= 1'b1;
                        r_state <= ST_SMUL;
                    end
                end
                ST_SQRT: begin
                    if (w_du_rsp.done) begin
                        r_n     <= w_du_rsp.res;
                        r_i     <= 2'd0;
                        r_state <= ST_QMUL;
                    end
                end
                ST_QMUL: r_state <= ST_QDIV;
                ST_QDIV: begin
                    r_neg   <= r_prod[63];
                    r_state <= ST_QWAIT;
                end
                ST_QWAIT: begin
                    if (w_du_rsp.done) begin
                        if (r_ph) begin
                            r_force[r_i] <= w_q[31:0];
                        end else begin
                            r_force[r_i] <= pflim_pkg::sat32(64'(r_prev[r_i]) + 64'(w_q));
                        end
                        if (r_i == 2'd2) begin
                            r_i <= 2'd0;
                            if (r_ph) begin
                                r_state <= ST_OUT;
                            end else begin
                                r_ph    <= 1'b1;
                                r_state <= ST_SMUL;
                            end
                        end else begin
                            r_i     <= r_i + 2'd1;
                            r_state <= ST_QMUL;
                        end
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        o_out_valid       <= 1'b1;
                        o_force_x         <= r_force[0];
                        o_force_y         <= r_force[1];
                        o_force_z         <= r_force[2];
                        o_motion_target_x <= w_mt[0];
                        o_motion_target_y <= w_mt[1];
                        o_motion_target_z <= w_mt[2];
                        o_slew_limited    <= r_slew;
                        o_norm_clamped    <= r_clamp;
                        for (int m = 0; m < 3; m++) begin
                            r_prev[m] <= r_force[m];
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
